// File: src/lcf_pkg.sv
// Shared types, register indexes and constant tables for the LRN forward unit.
`timescale 1ns / 1ps
package lcf_pkg;

  localparam int SUM_W = 36;

  typedef enum logic [2:0] {
    REG_WINDOW_SIZE = 3'd0,
    REG_FRONT_PAD   = 3'd1,
    REG_ALPHA       = 3'd2,
    REG_BIAS        = 3'd3,
    REG_BETA        = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [4:0]  window_size;
    logic [3:0]  front_pad;
    logic [31:0] alpha_scale;
    logic [31:0] bias;
    logic [15:0] beta;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [SUM_W-1:0]   sum;
    logic               last;
  } job_t;

  typedef logic [31:0] exp2_tab_t [16];

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    r   = '0;
    b   = 64'd1 << 62;
    rem = v;
    for (int k = 0; k < 32; k++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // entry i holds 2^(2^-(i+1)) in Q1.30
  function automatic exp2_tab_t build_exp2_tab();
    exp2_tab_t   t;
    logic [63:0] c;
    c = 64'd1 << 31;
    for (int i = 0; i < 16; i++) begin
      c    = isqrt64(c << 30);
      t[i] = c[31:0];
    end
    return t;
  endfunction

  localparam exp2_tab_t EXP2_C = build_exp2_tab();

endpackage

// File: src/lcf_in_if.sv
// Input stream channel: one channel activation per beat.
`timescale 1ns / 1ps
interface lcf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last_channel;
  modport source (output valid, sample, last_channel, input ready);
  modport sink (input valid, sample, last_channel, output ready);
endinterface

// File: src/lcf_out_if.sv
// Output stream channel: one normalized activation per beat.
`timescale 1ns / 1ps
interface lcf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normalized;
  logic               last_of_pixel;
  modport source (output valid, normalized, last_of_pixel, input ready);
  modport sink (input valid, normalized, last_of_pixel, output ready);
endinterface

// File: src/lcf_job_fifo.sv
// Small job queue between the window front end and the power back end.
`timescale 1ns / 1ps
module lcf_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lcf_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output lcf_pkg::job_t pop_data_o,
  output logic          empty_o
);
  lcf_pkg::job_t mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  assign full_o     = (cnt_q == 3'd4);
  assign empty_o    = (cnt_q == 3'd0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        mem_q[wr_q] <= push_data_i;
        wr_q        <= wr_q + 2'd1;
      end
      if (pop_i) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, push_i} - {2'b0, pop_i};
    end
  end
endmodule

// File: src/lcf_front.sv
// Front end: takes samples, keeps the square window, sums windows and issues jobs.
`timescale 1ns / 1ps
module lcf_front #(
  parameter int MAX_WINDOW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lcf_pkg::cfg_t cfg_i,
  lcf_in_if.sink        in_if,
  output logic          push_o,
  output lcf_pkg::job_t push_data_o,
  input  logic          full_i
);
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  typedef enum logic [1:0] {S_IDLE, S_SUM, S_PUSH, S_FLUSH} state_e;

  state_e st_q;
  logic [31:0]              sq_q [MAX_WINDOW];
  logic signed [15:0]       smp_q [MAX_WINDOW];
  logic [lcf_pkg::SUM_W-1:0] acc_q;
  logic [IDX_W-1:0]         idx_q, lo_q, hi_q, lag_q;
  logic [CNT_W-1:0]         j_q, nflush_q;
  logic [4:0]               seen_q;
  logic                     last_q, flag_q;

  logic [CNT_W-1:0] ws_w, nflush_w;
  logic [IDX_W-1:0] wsm1_w, fp_w, lag_w, hi_w, lo_w;
  logic             emit_w, flush_done_w, flush_emit_w;
  logic signed [31:0] sq_w;

  always_comb begin
    if (cfg_i.window_size == 5'd0) ws_w = CNT_W'(1);
    else if (int'(cfg_i.window_size) > MAX_WINDOW) ws_w = CNT_W'(MAX_WINDOW);
    else ws_w = CNT_W'(cfg_i.window_size);
    wsm1_w = IDX_W'(ws_w - CNT_W'(1));
    if (int'(cfg_i.front_pad) > MAX_WINDOW - 1) fp_w = IDX_W'(MAX_WINDOW - 1);
    else fp_w = IDX_W'(cfg_i.front_pad);
    lag_w = (wsm1_w > fp_w) ? wsm1_w - fp_w : '0;
    hi_w  = lag_w + fp_w;
    lo_w  = hi_w - wsm1_w;
    emit_w = int'(seen_q) >= int'(lag_w);
    if (int'(seen_q) + 1 < int'(lag_w)) nflush_w = CNT_W'(int'(seen_q) + 1);
    else nflush_w = CNT_W'(lag_w);
    flush_done_w = int'(j_q) > int'(lag_q);
    flush_emit_w = int'(j_q) > int'(lag_q) - int'(nflush_q);
  end

  assign sq_w        = in_if.sample * in_if.sample;
  assign in_if.ready = (st_q == S_IDLE);
  assign push_o      = (st_q == S_PUSH) && !full_i;
  assign push_data_o = '{sample: smp_q[lag_q], sum: acc_q, last: flag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      acc_q    <= '0;
      idx_q    <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      lag_q    <= '0;
      j_q      <= '0;
      nflush_q <= '0;
      seen_q   <= '0;
      last_q   <= 1'b0;
      flag_q   <= 1'b0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        sq_q[i]  <= '0;
        smp_q[i] <= '0;
      end
    end else begin
      unique case (st_q)
        S_IDLE: begin
          if (in_if.valid) begin
            for (int i = MAX_WINDOW - 1; i > 0; i--) begin
              sq_q[i]  <= sq_q[i-1];
              smp_q[i] <= smp_q[i-1];
            end
            sq_q[0]  <= unsigned'(sq_w);
            smp_q[0] <= in_if.sample;
            lag_q    <= lag_w;
            lo_q     <= lo_w;
            hi_q     <= hi_w;
            nflush_q <= nflush_w;
            last_q   <= in_if.last_channel;
            j_q      <= CNT_W'(1);
            seen_q   <= (seen_q == 5'd31) ? 5'd31 : seen_q + 5'd1;
            flag_q   <= (lag_w == '0) && in_if.last_channel;
            acc_q    <= '0;
            idx_q    <= lo_w;
            if (emit_w) st_q <= S_SUM;
            else if (in_if.last_channel) st_q <= S_FLUSH;
          end
        end
        S_SUM: begin
          acc_q <= acc_q + lcf_pkg::SUM_W'(sq_q[idx_q]);
          idx_q <= idx_q + IDX_W'(1);
          if (idx_q == hi_q) st_q <= S_PUSH;
        end
        S_PUSH: begin
          if (!full_i) st_q <= last_q ? S_FLUSH : S_IDLE;
        end
        S_FLUSH: begin
          if (flush_done_w) begin
            for (int i = 0; i < MAX_WINDOW; i++) begin
              sq_q[i]  <= '0;
              smp_q[i] <= '0;
            end
            seen_q <= '0;
            st_q   <= S_IDLE;
          end else begin
            for (int i = MAX_WINDOW - 1; i > 0; i--) begin
              sq_q[i]  <= sq_q[i-1];
              smp_q[i] <= smp_q[i-1];
            end
            sq_q[0]  <= '0;
            smp_q[0] <= '0;
            flag_q   <= (int'(j_q) == int'(lag_q));
            j_q      <= j_q + CNT_W'(1);
            acc_q    <= '0;
            idx_q    <= lo_q;
            if (flush_emit_w) st_q <= S_SUM;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i) else $error("push into full queue");
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> !in_if.ready) else $error("ready while busy");
  a_pixel_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_FLUSH && flush_done_w) |=> (seen_q == 5'd0 && sq_q[0] == '0))
    else $error("pixel state not cleared");
endmodule

// File: src/lcf_back.sv
// Back end: scale, iterative log2 / exp2 power and rounding of one job at a time.
`timescale 1ns / 1ps
module lcf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lcf_pkg::cfg_t cfg_i,
  input  lcf_pkg::job_t job_i,
  input  logic          empty_i,
  output logic          pop_o,
  lcf_out_if.source     out_if
);
  typedef enum logic [3:0] {
    B_IDLE, B_MHI, B_MLO, B_SCALE, B_NORM, B_LOG, B_EXPN, B_EXP, B_PROD, B_RND, B_OUT
  } state_e;

  state_e st_q;
  logic signed [15:0]        x_q;
  logic [lcf_pkg::SUM_W-1:0] sum_q;
  logic                      flag_q;
  logic [51:0]               phi_q, plo_q;
  logic [31:0]               m_q;
  logic [4:0]                e_q;
  logic [15:0]               frac_q, mag_q;
  logic [3:0]                it_q;
  logic signed [40:0]        ne_q;
  logic [31:0]               acc_q;
  logic [63:0]               prod_q;
  logic signed [15:0]        res_q;
  logic                      ov_q, olast_q;
  logic signed [15:0]        onorm_q;

  logic [52:0]        t_w;
  logic [32:0]        scale_sum_w;
  logic [31:0]        scale_w;
  logic [63:0]        msq_w, amul_w, res_w;
  logic signed [21:0] logv_w;
  logic signed [40:0] eqv_w;
  logic signed [10:0] n_w;
  logic signed [11:0] sh_w;
  logic [15:0]        f_w;
  logic [16:0]        mag_w;
  logic               out_load_w;

  always_comb begin
    t_w         = {1'b0, phi_q} + 53'(plo_q >> 16);
    scale_sum_w = {1'b0, cfg_i.bias} + 33'(t_w >> 24);
    scale_w     = scale_sum_w[32] ? 32'hFFFF_FFFF : scale_sum_w[31:0];
    mag_w       = x_q[15] ? 17'(-$signed({x_q[15], x_q})) : 17'(x_q);
    msq_w       = 64'(m_q) * 64'(m_q);
    logv_w      = {6'({1'b0, e_q} - 6'd24), frac_q};
    eqv_w       = ne_q >>> 14;
    f_w         = eqv_w[15:0];
    n_w         = 11'(ne_q >>> 30);
    amul_w      = 64'(acc_q) * 64'(lcf_pkg::EXP2_C[it_q]);
    sh_w        = 12'sd30 - 12'(n_w);
    if (sh_w <= 12'sd0) res_w = 64'd1 << 20;
    else if (sh_w >= 12'sd63) res_w = '0;
    else res_w = (prod_q + (64'd1 << (sh_w[5:0] - 6'd1))) >> sh_w[5:0];
  end

  assign pop_o      = (st_q == B_IDLE) && !empty_i;
  assign out_load_w = (st_q == B_OUT) && (!ov_q || out_if.ready);

  assign out_if.valid         = ov_q;
  assign out_if.normalized    = onorm_q;
  assign out_if.last_of_pixel = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= B_IDLE;
      ov_q    <= 1'b0;
      olast_q <= 1'b0;
      onorm_q <= '0;
      it_q    <= '0;
    end else begin
      if (out_load_w) ov_q <= 1'b1;
      else if (ov_q && out_if.ready) ov_q <= 1'b0;
      unique case (st_q)
        B_IDLE: begin
          if (!empty_i) begin
            x_q    <= job_i.sample;
            sum_q  <= job_i.sum;
            flag_q <= job_i.last;
            st_q   <= B_MHI;
          end
        end
        B_MHI: begin
          phi_q <= 52'(sum_q) * 52'(cfg_i.alpha_scale[31:16]);
          st_q  <= B_MLO;
        end
        B_MLO: begin
          plo_q <= 52'(sum_q) * 52'(cfg_i.alpha_scale[15:0]);
          st_q  <= B_SCALE;
        end
        B_SCALE: begin
          mag_q <= mag_w[15:0];
          m_q   <= scale_w;
          e_q   <= 5'd31;
          if (x_q == '0) begin
            res_q <= '0;
            st_q  <= B_OUT;
          end else if (scale_w == '0) begin
            if (cfg_i.beta == '0) res_q <= x_q;
            else res_q <= x_q[15] ? 16'sh8000 : 16'sh7FFF;
            st_q <= B_OUT;
          end else begin
            st_q <= B_NORM;
          end
        end
        B_NORM: begin
          if (m_q[31]) begin
            frac_q <= '0;
            it_q   <= '0;
            st_q   <= B_LOG;
          end else begin
            m_q <= m_q << 1;
            e_q <= e_q - 5'd1;
          end
        end
        B_LOG: begin
          frac_q <= {frac_q[14:0], msq_w[63]};
          m_q    <= msq_w[63] ? msq_w[63:32] : msq_w[62:31];
          it_q   <= it_q + 4'd1;
          if (it_q == 4'd15) st_q <= B_EXPN;
        end
        B_EXPN: begin
          ne_q  <= -(41'(signed'({1'b0, cfg_i.beta})) * 41'(logv_w));
          acc_q <= 32'd1 << 30;
          it_q  <= '0;
          st_q  <= B_EXP;
        end
        B_EXP: begin
          if (f_w[4'd15 - it_q]) acc_q <= amul_w[61:30];
          it_q <= it_q + 4'd1;
          if (it_q == 4'd15) st_q <= B_PROD;
        end
        B_PROD: begin
          prod_q <= 64'(mag_q) * 64'(acc_q);
          st_q   <= B_RND;
        end
        B_RND: begin
          if (x_q[15]) res_q <= (res_w >= 64'd32768) ? 16'sh8000 : 16'(-res_w[15:0]);
          else res_q <= (res_w >= 64'd32767) ? 16'sh7FFF : 16'(res_w[15:0]);
          st_q <= B_OUT;
        end
        B_OUT: begin
          if (out_load_w) begin
            onorm_q <= res_q;
            olast_q <= flag_q;
            st_q    <= B_IDLE;
          end
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (st_q == B_MHI)) else $error("pop without start");
  a_log_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_LOG) |-> m_q[31]) else $error("log mantissa not normalized");
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_w |=> ov_q) else $error("result load lost");
endmodule

// File: src/lrn_cross_channel_forward_unit.sv
// Top level: config registers, front end, job queue and power back end.
// Flow: the front end sums each issued window; the back end normalizes scale, then runs
//   its 32x32 log2 and exp2 loops, skipped when x or scale is zero, on one job at a time;
//   the front end runs ahead through a four-entry job queue.
// Reset: asynchronous active low; clears windows, pixel count, queue and registers
//   to their defaults at once.
`timescale 1ns / 1ps
module lrn_cross_channel_forward_unit #(
  parameter int MAX_WINDOW = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  lcf_in_if.sink      in_if,
  lcf_out_if.source   out_if
);
  lcf_pkg::cfg_t cfg_q;
  lcf_pkg::job_t push_data, pop_data;
  logic push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_size <= 5'd5;
      cfg_q.front_pad   <= 4'd2;
      cfg_q.alpha_scale <= 32'd85899;
      cfg_q.bias        <= 32'd16777216;
      cfg_q.beta        <= 16'd12288;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lcf_pkg::REG_WINDOW_SIZE: cfg_q.window_size <= cfg_data_i[4:0];
        lcf_pkg::REG_FRONT_PAD:   cfg_q.front_pad   <= cfg_data_i[3:0];
        lcf_pkg::REG_ALPHA:       cfg_q.alpha_scale <= cfg_data_i;
        lcf_pkg::REG_BIAS:        cfg_q.bias        <= cfg_data_i;
        lcf_pkg::REG_BETA:        cfg_q.beta        <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  lcf_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_if(in_if),
    .push_o(push), .push_data_o(push_data), .full_i(full)
  );

  lcf_job_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .pop_data_o(pop_data), .empty_o(empty)
  );

  lcf_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .job_i(pop_data), .empty_i(empty),
    .pop_o(pop), .out_if(out_if)
  );
endmodule

// File: sim/lcf_checker.sv
// Checker for the LRN forward unit: predicts normalized outputs and compares each beat.
`timescale 1ns / 1ps
module lcf_checker #(
  parameter int MAX_WINDOW = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  lcf_in_if           in_ch,
  lcf_out_if          out_ch,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [15:0] normalized;
    logic        last_of_pixel;
  } norm_beat_t;

  lcf_pkg::cfg_t regs;
  logic [31:0]   sq_hist [MAX_WINDOW];
  logic [15:0]   x_hist [MAX_WINDOW];
  int            seen;
  norm_beat_t    norm_q [$];
  int            errors;

  assign errors_o  = errors;
  assign pending_o = norm_q.size();

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2 of nonzero Q8.24 value, Q.16
  function automatic longint log2_fix(logic [31:0] s);
    int          e;
    logic [63:0] m;
    longint      fr;
    e  = 31;
    fr = 0;
    while (s[e] == 1'b0) e--;
    m = 64'(s) << (31 - e);
    for (int i = 0; i < 16; i++) begin
      m  = (m * m) >> 31;
      fr = fr << 1;
      if (m >= (64'd1 << 32)) begin
        fr = fr | 1;
        m  = m >> 1;
      end
    end
    return (longint'(e) - 24) * 65536 + fr;
  endfunction

  // 2^f, f in Q0.16, result Q1.30
  function automatic logic [63:0] pow2_frac(logic [15:0] f);
    logic [63:0] c, acc;
    c   = 64'd1 << 31;
    acc = 64'd1 << 30;
    for (int i = 1; i <= 16; i++) begin
      c = int_sqrt(c << 30);
      if (f[16-i]) acc = (acc * c) >> 30;
    end
    return acc;
  endfunction

  function automatic logic [15:0] apply_power(int x, logic [31:0] scale);
    int          mag;
    logic [63:0] res, biased, prod;
    longint      ne, n, sh;
    mag = (x < 0) ? -x : x;
    if (mag == 0) return 16'd0;
    if (scale == 0) begin
      if (regs.beta == 0) return x[15:0];
      return (x < 0) ? 16'h8000 : 16'h7fff;
    end
    ne     = -(longint'(regs.beta) * log2_fix(scale));
    biased = 64'(ne + (longint'(128) << 30)) >> 14;
    n      = longint'(biased >> 16) - 128;
    prod   = 64'(mag) * pow2_frac(biased[15:0]);
    sh     = 30 - n;
    if (sh <= 0) res = 64'd1 << 20;
    else if (sh >= 63) res = 0;
    else res = (prod + (64'd1 << (sh - 1))) >> sh;
    if (x < 0) return (res >= 32768) ? 16'h8000 : 16'(-int'(res));
    return (res >= 32767) ? 16'h7fff : res[15:0];
  endfunction

  function automatic norm_beat_t window_result(int lo, int hi, int lag, logic flag);
    logic [63:0] s, t;
    logic [35:0] wsum;
    logic [31:0] term, scale;
    norm_beat_t  b;
    s = 0;
    for (int i = lo; i <= hi; i++) s += sq_hist[i];
    wsum  = s[35:0];
    t     = 64'(wsum) * regs.alpha_scale[31:16]
          + ((64'(wsum) * regs.alpha_scale[15:0]) >> 16);
    term  = t[55:24];
    scale = (33'(regs.bias) + term > 33'h0ffffffff) ? 32'hffffffff : regs.bias + term;
    b.normalized    = apply_power(int'($signed(x_hist[lag])), scale);
    b.last_of_pixel = flag;
    return b;
  endfunction

  task automatic shift_in(logic [31:0] sq, logic [15:0] raw);
    for (int i = MAX_WINDOW - 1; i > 0; i--) begin
      sq_hist[i] = sq_hist[i-1];
      x_hist[i]  = x_hist[i-1];
    end
    sq_hist[0] = sq;
    x_hist[0]  = raw;
  endtask

  task automatic clear_pixel();
    for (int i = 0; i < MAX_WINDOW; i++) begin
      sq_hist[i] = '0;
      x_hist[i]  = '0;
    end
    seen = 0;
  endtask

  task automatic predict_beat(logic [15:0] raw, logic last);
    int ws, fp, lag, lo, hi, k, nflush, x;
    ws = regs.window_size;
    fp = regs.front_pad;
    if (ws < 1) ws = 1;
    if (ws > MAX_WINDOW) ws = MAX_WINDOW;
    if (fp > MAX_WINDOW - 1) fp = MAX_WINDOW - 1;
    lag = (ws - 1 > fp) ? ws - 1 - fp : 0;
    hi  = lag + fp;
    lo  = hi - (ws - 1);
    x   = int'($signed(raw));
    shift_in(32'(x * x), raw);
    k = seen;
    if (k >= lag) norm_q.push_back(window_result(lo, hi, lag, (lag == 0) && last));
    seen = (k + 1 > 31) ? 31 : k + 1;
    if (last) begin
      nflush = (k + 1 < lag) ? k + 1 : lag;
      for (int j = 1; j <= lag; j++) begin
        shift_in('0, '0);
        if (j > lag - nflush) norm_q.push_back(window_result(lo, hi, lag, j == lag));
      end
      clear_pixel();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    norm_beat_t e;
    if (!rst_ni) begin
      regs.window_size <= 5'd5;
      regs.front_pad   <= 4'd2;
      regs.alpha_scale <= 32'd85899;
      regs.bias        <= 32'd16777216;
      regs.beta        <= 16'd12288;
      clear_pixel();
      norm_q.delete();
      errors = 0;
    end else begin
      if (cfg_we_i) begin
        case (lcf_pkg::reg_idx_e'(cfg_idx_i))
          lcf_pkg::REG_WINDOW_SIZE: regs.window_size <= cfg_data_i[4:0];
          lcf_pkg::REG_FRONT_PAD:   regs.front_pad   <= cfg_data_i[3:0];
          lcf_pkg::REG_ALPHA:       regs.alpha_scale <= cfg_data_i;
          lcf_pkg::REG_BIAS:        regs.bias        <= cfg_data_i;
          lcf_pkg::REG_BETA:        regs.beta        <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (norm_q.size() == 0) begin
          $error("unexpected beat: normalized %h last_of_pixel %b",
                 out_ch.normalized, out_ch.last_of_pixel);
          errors = errors + 1;
        end else begin
          e = norm_q.pop_front();
          if (out_ch.normalized !== e.normalized) begin
            $error("normalized: expected %h actual %h", e.normalized, out_ch.normalized);
            errors = errors + 1;
          end
          if (out_ch.last_of_pixel !== e.last_of_pixel) begin
            $error("last_of_pixel: expected %b actual %b",
                   e.last_of_pixel, out_ch.last_of_pixel);
            errors = errors + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) predict_beat(in_ch.sample, in_ch.last_channel);
    end
  end

endmodule

// File: sim/tb_lrn_cross_channel_forward_unit.sv
// Testbench top: drives config, pixel streams and output back-pressure, gives the verdict.
`timescale 1ns / 1ps
module tb_lrn_cross_channel_forward_unit;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int HOLD_CYCLES    = 2500;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = lcf_pkg::REG_WINDOW_SIZE;
  logic [31:0] cfg_data_i = '0;
  int          errors, pending;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;
  int          quiet_cycles = 0;

  lcf_in_if  in_ch ();
  lcf_out_if out_ch ();

  always #5 clk_i = ~clk_i;

  lrn_cross_channel_forward_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if(in_ch), .out_if(out_ch)
  );

  lcf_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_ch, .out_ch, .errors_o(errors), .pending_o(pending)
  );

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.sample       = '0;
    in_ch.last_channel = 1'b0;
    out_ch.ready       = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // output back-pressure
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  task automatic write_reg(lcf_pkg::reg_idx_e idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic configure(logic [4:0] ws, logic [3:0] fp, logic [31:0] a,
                           logic [31:0] b, logic [15:0] be);
    write_reg(lcf_pkg::REG_WINDOW_SIZE, 32'(ws));
    write_reg(lcf_pkg::REG_FRONT_PAD, 32'(fp));
    write_reg(lcf_pkg::REG_ALPHA, a);
    write_reg(lcf_pkg::REG_BIAS, b);
    write_reg(lcf_pkg::REG_BETA, 32'(be));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_beat(logic [15:0] s, logic last);
    if (!no_idle && $urandom_range(0, 6) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample       <= s;
    in_ch.last_channel <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0, 1: return 16'($urandom);
      2: begin
        case ($urandom_range(0, 4))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'h0001;
          default: return 16'hffff;
        endcase
      end
      3, 4: return 16'($signed($urandom_range(0, 1023)) - 512);
      default: return 16'($signed($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  task automatic send_pixels(int n_beats);
    int len, c;
    c = 0;
    while (c < n_beats) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 34) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) send_beat(pick_sample(), i == len - 1);
      c += len;
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes at reset config, short and zero pixels
    send_beat(16'h7fff, 1'b0);
    send_beat(16'h8000, 1'b0);
    send_beat(16'h0000, 1'b0);
    send_beat(16'h0001, 1'b0);
    send_beat(16'hffff, 1'b0);
    send_beat(16'h0100, 1'b0);
    send_beat(16'hff00, 1'b1);
    send_beat(16'h4000, 1'b1);
    send_beat(16'h0000, 1'b0);
    send_beat(16'h0000, 1'b1);
    send_beat(16'h1234, 1'b0);
    send_beat(16'hedcc, 1'b1);
    drain();
    // zero scale, with and without beta
    configure(5'd3, 4'd1, 32'd0, 32'd0, 16'd0);
    send_beat(16'h8000, 1'b0);
    send_beat(16'h0000, 1'b0);
    send_beat(16'h7fff, 1'b1);
    drain();
    configure(5'd3, 4'd1, 32'd0, 32'd0, 16'd12288);
    send_beat(16'h8000, 1'b0);
    send_beat(16'h0000, 1'b0);
    send_beat(16'h7fff, 1'b1);
    drain();

    configure(5'd5, 4'd2, 32'd85899, 32'd16777216, 16'd12288);
    send_pixels(30);
    hold_req = 1'b1;
    send_pixels(30);
    drain();
    configure(5'd1, 4'd0, $urandom, 32'd1 << 24, 16'($urandom));
    send_pixels(30);
    drain();
    configure(5'd16, 4'd15, 32'hffffffff, 32'hffffffff, 16'hffff);
    send_pixels(30);
    drain();
    configure(5'd31, 4'd0, 32'd1 << 28, 32'd1 << 20, 16'd16384);
    send_pixels(30);
    drain();
    configure(5'd0, 4'd15, 32'd0, 32'd0, 16'd0);
    send_pixels(25);
    drain();
    configure(5'd16, 4'd0, 32'($urandom), 32'($urandom), 16'hffff);
    send_pixels(30);
    drain();
    configure(5'($urandom_range(2, 16)), 4'($urandom), 32'($urandom), 32'($urandom),
              16'($urandom));
    send_pixels(35);
    drain();
    no_idle = 1'b1;
    configure(5'd7, 4'd3, 32'd85899 * 40, 32'd1 << 23, 16'd12288);
    send_pixels(35);
    drain();

    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// File: lrn_cross_channel_forward_unit.f
src/lcf_pkg.sv
src/lcf_in_if.sv
src/lcf_out_if.sv
src/lcf_job_fifo.sv
src/lcf_front.sv
src/lcf_back.sv
src/lrn_cross_channel_forward_unit.sv
sim/lcf_checker.sv
sim/tb_lrn_cross_channel_forward_unit.sv
